// ===== hdl/grid_index_linearizer_defines.svh =====
// Assertion macros shared by the grid index linearizer.
`ifndef GRID_INDEX_LINEARIZER_DEFINES_SVH
`define GRID_INDEX_LINEARIZER_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define GIL_ASSERT_IMP(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("gil assertion failed");
`define GIL_ASSERT_NXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("gil assertion failed");
`else
`define GIL_ASSERT_IMP(label, clk, rst, lhs, rhs)
`define GIL_ASSERT_NXT(label, clk, rst, lhs, rhs)
`endif
`endif

// ===== hdl/gil_pkg.sv =====
// Types, constants and helper functions of the grid index linearizer.
package gil_pkg;
   localparam int MAX_DIM     = 1024;
   localparam int REG_W       = 11;
   localparam int COORD_W     = 10;
   localparam int IDX_W       = 30;
   localparam int PLANE_W     = 21;
   localparam int REM_W       = 22;
   localparam int K_STEPS     = 30;
   localparam int J_STEPS     = 20;
   localparam int N_CELLS     = K_STEPS + J_STEPS;

   localparam logic [1:0] REG_NODES_I = 2'd0;
   localparam logic [1:0] REG_NODES_J = 2'd1;
   localparam logic [1:0] REG_NODES_K = 2'd2;

   localparam int CMD_INV_BIT  = 0;
   localparam int CMD_CELL_BIT = 1;

   typedef struct packed {
      logic                 valid;
      logic                 inv;
      logic                 err;
      logic [IDX_W-1:0]     flat;
      logic [IDX_W-1:0]     num;
      logic [REM_W-1:0]     rem;
      logic [PLANE_W-1:0]   dvs;
      logic [REG_W-1:0]     ei;
      logic [COORD_W-1:0]   kq;
   } cell_type;

   function automatic logic [REG_W-1:0] clamp_ext(input logic [REG_W-1:0] n);
      logic [REG_W-1:0] r;
      if (n < REG_W'(2)) begin
         r = REG_W'(2);
      end else if (n > REG_W'(MAX_DIM)) begin
         r = REG_W'(MAX_DIM);
      end else begin
         r = n;
      end
      return r;
   endfunction

   function automatic logic [COORD_W-1:0] sat_coord(input logic [IDX_W-1:0] v);
      logic [COORD_W-1:0] r;
      if (|v[IDX_W-1:COORD_W]) begin
         r = {COORD_W{1'b1}};
      end else begin
         r = v[COORD_W-1:0];
      end
      return r;
   endfunction
endpackage

// ===== hdl/gil_front.sv =====
// Front stages: extents, plane size, products and range limits.
module gil_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  logic                      in_valid,
   input  logic [1:0]                cmd,
   input  logic [9:0]                coord_i,
   input  logic [9:0]                coord_j,
   input  logic [9:0]                coord_k,
   input  logic [29:0]               flat_index,
   input  logic [10:0]               nodes_i,
   input  logic [10:0]               nodes_j,
   input  logic [10:0]               nodes_k,
   output gil_pkg::cell_type         head
);
   logic        v1_ff, v2_ff, v3_ff;
   logic        inv1_ff, inv2_ff, inv3_ff;
   logic [9:0]  ci1_ff, cj1_ff, ck1_ff, ck2_ff;
   logic [9:0]  ci2_ff;
   logic [29:0] idx1_ff, idx2_ff, idx3_ff;
   logic [10:0] ei1_ff, ej1_ff, ek1_ff, ei2_ff, ek2_ff, ei3_ff;
   logic [20:0] plane2_ff, cjei2_ff, plane3_ff, base3_ff;
   logic        rerr2_ff, rerr3_ff;
   logic [30:0] kp3_ff, lim3_ff;
   logic [10:0] ei_in, ej_in, ek_in;
   logic [21:0] plane_full, cjei_full;
   logic [31:0] kp_full, lim_full;
   logic [30:0] sum;

   always_comb begin
      ei_in = gil_pkg::clamp_ext(nodes_i);
      ej_in = gil_pkg::clamp_ext(nodes_j);
      ek_in = gil_pkg::clamp_ext(nodes_k);
      if (cmd[gil_pkg::CMD_CELL_BIT]) begin
         ei_in = ei_in - 11'd1;
         ej_in = ej_in - 11'd1;
         ek_in = ek_in - 11'd1;
      end
      plane_full = ei1_ff * ej1_ff;
      cjei_full  = {12'd0, cj1_ff} * {11'd0, ei1_ff};
      kp_full    = {22'd0, ck2_ff} * {11'd0, plane2_ff};
      lim_full   = {11'd0, plane2_ff} * {21'd0, ek2_ff};
      sum        = kp3_ff + {10'd0, base3_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
      if (en) begin
         inv1_ff   <= cmd[gil_pkg::CMD_INV_BIT];
         ci1_ff    <= coord_i;
         cj1_ff    <= coord_j;
         ck1_ff    <= coord_k;
         idx1_ff   <= flat_index;
         ei1_ff    <= ei_in;
         ej1_ff    <= ej_in;
         ek1_ff    <= ek_in;
         inv2_ff   <= inv1_ff;
         ci2_ff    <= ci1_ff;
         ck2_ff    <= ck1_ff;
         idx2_ff   <= idx1_ff;
         ei2_ff    <= ei1_ff;
         ek2_ff    <= ek1_ff;
         plane2_ff <= plane_full[20:0];
         cjei2_ff  <= cjei_full[20:0];
         rerr2_ff  <= ({1'b0, ci1_ff} >= ei1_ff) || ({1'b0, cj1_ff} >= ej1_ff) ||
                      ({1'b0, ck1_ff} >= ek1_ff);
         inv3_ff   <= inv2_ff;
         idx3_ff   <= idx2_ff;
         ei3_ff    <= ei2_ff;
         plane3_ff <= plane2_ff;
         base3_ff  <= cjei2_ff + {11'd0, ci2_ff};
         rerr3_ff  <= rerr2_ff;
         kp3_ff    <= kp_full[30:0];
         lim3_ff   <= lim_full[30:0];
      end
   end

   always_comb begin
      head.valid = v3_ff;
      head.inv   = inv3_ff;
      head.num   = idx3_ff;
      head.rem   = '0;
      head.dvs   = plane3_ff;
      head.ei    = ei3_ff;
      head.kq    = '0;
      if (inv3_ff) begin
         head.err  = {1'b0, idx3_ff} >= lim3_ff;
         head.flat = '0;
      end else begin
         head.err  = rerr3_ff || sum[30];
         head.flat = sum[29:0];
      end
   end
endmodule

// ===== hdl/gil_div_cell.sv =====
// One restoring division step of the divider chain.
module gil_div_cell (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  gil_pkg::cell_type  d_in,
   output gil_pkg::cell_type  d_out
);
   gil_pkg::cell_type        step_ff, step_in;
   logic [gil_pkg::REM_W-1:0] trial;

   always_comb begin
      step_in = d_in;
      trial   = {d_in.rem[gil_pkg::REM_W-2:0], d_in.num[gil_pkg::IDX_W-1]};
      if (trial >= {1'b0, d_in.dvs}) begin
         step_in.rem = trial - {1'b0, d_in.dvs};
         step_in.num = {d_in.num[gil_pkg::IDX_W-2:0], 1'b1};
      end else begin
         step_in.rem = trial;
         step_in.num = {d_in.num[gil_pkg::IDX_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff.valid <= 1'b0;
      end else if (en) begin
         step_ff.valid <= step_in.valid;
      end
      if (en) begin
         step_ff.inv  <= step_in.inv;
         step_ff.err  <= step_in.err;
         step_ff.flat <= step_in.flat;
         step_ff.num  <= step_in.num;
         step_ff.rem  <= step_in.rem;
         step_ff.dvs  <= step_in.dvs;
         step_ff.ei   <= step_in.ei;
         step_ff.kq   <= step_in.kq;
      end
   end

   assign d_out = step_ff;
endmodule

// ===== hdl/grid_index_linearizer.sv =====
// Grid index linearizer: converts coordinates to a row-major index and back.
// One word is accepted per cycle while not stalled; each word gives one result:
// three front stages form the extents, the plane size and the products, then a
// chain of fifty division cells yields one quotient bit each (thirty for the
// plane quotient, twenty for the row quotient). The whole pipeline holds while
// a finished result waits to be taken.
`include "grid_index_linearizer_defines.svh"
module grid_index_linearizer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_cmd,
   input  logic [9:0]  req_coord_i,
   input  logic [9:0]  req_coord_j,
   input  logic [9:0]  req_coord_k,
   input  logic [29:0] req_flat_index,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [29:0] rsp_flat_result,
   output logic [9:0]  rsp_out_i,
   output logic [9:0]  rsp_out_j,
   output logic [9:0]  rsp_out_k,
   output logic        rsp_range_error,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [10:0] csr_wdata
);
   logic [10:0]       nodes_i_ff, nodes_j_ff, nodes_k_ff;
   logic              en;
   gil_pkg::cell_type chain [0:gil_pkg::N_CELLS];
   gil_pkg::cell_type mid;
   gil_pkg::cell_type last;

   always_ff @(posedge clock) begin
      if (reset) begin
         nodes_i_ff <= 11'd2;
         nodes_j_ff <= 11'd2;
         nodes_k_ff <= 11'd2;
      end else if (csr_we) begin
         case (csr_index)
            gil_pkg::REG_NODES_I: nodes_i_ff <= csr_wdata;
            gil_pkg::REG_NODES_J: nodes_j_ff <= csr_wdata;
            gil_pkg::REG_NODES_K: nodes_k_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign last = chain[gil_pkg::N_CELLS];
   assign en = !last.valid || rsp_ready;
   assign req_ready = en;

   gil_front u_front (
      .clock(clock), .reset(reset), .en(en), .in_valid(req_valid && en),
      .cmd(req_cmd), .coord_i(req_coord_i), .coord_j(req_coord_j),
      .coord_k(req_coord_k), .flat_index(req_flat_index),
      .nodes_i(nodes_i_ff), .nodes_j(nodes_j_ff), .nodes_k(nodes_k_ff),
      .head(chain[0])
   );

   // After the plane quotient, the remainder is left-aligned and divided by ei.
   always_comb begin
      mid      = chain[gil_pkg::K_STEPS];
      mid.kq   = gil_pkg::sat_coord(chain[gil_pkg::K_STEPS].num);
      mid.num  = {chain[gil_pkg::K_STEPS].rem[gil_pkg::J_STEPS-1:0],
                  {(gil_pkg::IDX_W-gil_pkg::J_STEPS){1'b0}}};
      mid.rem  = '0;
      mid.dvs  = {{(gil_pkg::PLANE_W-gil_pkg::REG_W){1'b0}}, chain[gil_pkg::K_STEPS].ei};
   end

   for (genvar c = 0; c < gil_pkg::N_CELLS; c++) begin : g_cell
      gil_div_cell u_cell (
         .clock(clock), .reset(reset), .en(en),
         .d_in((c == gil_pkg::K_STEPS) ? mid : chain[c]),
         .d_out(chain[c+1])
      );
   end

   assign rsp_valid       = last.valid;
   assign rsp_flat_result = last.flat;
   assign rsp_range_error = last.err;
   assign rsp_out_k       = last.inv ? last.kq : 10'd0;
   assign rsp_out_j       = last.inv ?
                            gil_pkg::sat_coord({10'd0, last.num[gil_pkg::J_STEPS-1:0]}) :
                            10'd0;
   assign rsp_out_i       = last.inv ? last.rem[9:0] : 10'd0;

   `GIL_ASSERT_IMP(a_ready_tracks_output, clock, reset, 1'b1, req_ready == (!rsp_valid || rsp_ready))
   `GIL_ASSERT_IMP(a_forward_no_coords, clock, reset, rsp_valid && !last.inv, rsp_out_k == 10'd0 && rsp_out_i == 10'd0)
   `GIL_ASSERT_NXT(a_stall_holds_chain, clock, reset, !en, $stable(chain[gil_pkg::N_CELLS]))
endmodule

// ===== sim/grid_index_linearizer_checker.sv =====
// Checker for the grid index linearizer: predicts each result word and compares it.
`timescale 1ns / 100ps
module grid_index_linearizer_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [1:0]  req_cmd,
   input  logic [9:0]  req_coord_i,
   input  logic [9:0]  req_coord_j,
   input  logic [9:0]  req_coord_k,
   input  logic [29:0] req_flat_index,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [29:0] rsp_flat_result,
   input  logic [9:0]  rsp_out_i,
   input  logic [9:0]  rsp_out_j,
   input  logic [9:0]  rsp_out_k,
   input  logic        rsp_range_error,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [10:0] csr_wdata,
   output int          fail_count,
   output int          pending
);
   typedef struct packed {
      logic [29:0] flat;
      logic [9:0]  oi;
      logic [9:0]  oj;
      logic [9:0]  ok;
      logic        err;
   } conv_result_type;

   conv_result_type conversions_due[$];
   logic [10:0] span_i = 11'd2, span_j = 11'd2, span_k = 11'd2;

   function automatic longint unsigned fit_span(input logic [10:0] n);
      if (n < 11'd2) return 2;
      if (n > 11'(gil_pkg::MAX_DIM)) return gil_pkg::MAX_DIM;
      return n;
   endfunction

   function automatic longint unsigned cap10(input longint unsigned v);
      return (v > 1023) ? 1023 : v;
   endfunction

   function automatic conv_result_type convert_address(input logic [1:0] cmd,
         input logic [9:0] ci, input logic [9:0] cj, input logic [9:0] ck,
         input logic [29:0] idx);
      conv_result_type r;
      longint unsigned ei, ej, ek, plane, full, rem;
      ei = fit_span(span_i);
      ej = fit_span(span_j);
      ek = fit_span(span_k);
      r = '0;
      if (cmd[gil_pkg::CMD_CELL_BIT]) begin
         ei--; ej--; ek--;
      end
      plane = ei * ej;
      if (!cmd[gil_pkg::CMD_INV_BIT]) begin
         full = ck * plane + cj * ei + ci;
         r.err = (ci >= ei) || (cj >= ej) || (ck >= ek) || (full > 64'h3FFFFFFF);
         r.flat = full[29:0];
      end else begin
         rem = idx % plane;
         r.err = idx >= plane * ek;
         r.ok = 10'(cap10(idx / plane));
         r.oj = 10'(cap10(rem / ei));
         r.oi = 10'(cap10(rem % ei));
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
      fail_count++;
   endtask

   initial begin
      fail_count = 0;
      pending = 0;
   end

   always @(posedge clock) begin
      conv_result_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (conversions_due.size() == 0) begin
               report_mismatch("unexpected word", 1, 0);
            end else begin
               want = conversions_due.pop_front();
               if (rsp_flat_result !== want.flat)
                  report_mismatch("flat_result", rsp_flat_result, want.flat);
               if (rsp_out_i !== want.oi) report_mismatch("out_i", rsp_out_i, want.oi);
               if (rsp_out_j !== want.oj) report_mismatch("out_j", rsp_out_j, want.oj);
               if (rsp_out_k !== want.ok) report_mismatch("out_k", rsp_out_k, want.ok);
               if (rsp_range_error !== want.err)
                  report_mismatch("range_error", rsp_range_error, want.err);
            end
         end
         if (req_valid && req_ready)
            conversions_due.push_back(convert_address(req_cmd, req_coord_i, req_coord_j,
               req_coord_k, req_flat_index));
         if (csr_we) begin
            case (csr_index)
               gil_pkg::REG_NODES_I: span_i = csr_wdata;
               gil_pkg::REG_NODES_J: span_j = csr_wdata;
               gil_pkg::REG_NODES_K: span_k = csr_wdata;
               default: ;
            endcase
         end
      end
      pending = conversions_due.size();
   end
endmodule

// ===== sim/grid_index_linearizer_tb.sv =====
// Testbench top for the grid index linearizer: stimulus, configuration and verdict.
`timescale 1ns / 100ps
module grid_index_linearizer_tb;
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_cmd = '0;
   logic [9:0]  req_coord_i = '0, req_coord_j = '0, req_coord_k = '0;
   logic [29:0] req_flat_index = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [29:0] rsp_flat_result;
   logic [9:0]  rsp_out_i, rsp_out_j, rsp_out_k;
   logic        rsp_range_error;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [10:0] csr_wdata = '0;
   int          fail_count, pending;
   int          send_gap = 0, take_gap = 0;
   int          idle_cycles = 0;
   bit          hold_off = 0;

   localparam int WATCHDOG = 20000;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   grid_index_linearizer u_dut (.*);

   grid_index_linearizer_checker u_chk (.*);

   always @(posedge clock) begin
      if (reset || hold_off) rsp_ready <= 1'b0;
      else rsp_ready <= ($urandom_range(99) >= take_gap);
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
         $display("Verification failed");
         $finish;
      end
   end

   task automatic send_word(input logic [1:0] cmd, input logic [9:0] ci,
         input logic [9:0] cj, input logic [9:0] ck, input logic [29:0] idx);
      while ($urandom_range(99) < send_gap) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_coord_i <= ci;
      req_coord_j <= cj;
      req_coord_k <= ck;
      req_flat_index <= idx;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic set_extents(input logic [10:0] ni, input logic [10:0] nj,
         input logic [10:0] nk);
      csr_we <= 1'b1;
      csr_index <= gil_pkg::REG_NODES_I; csr_wdata <= ni;
      @(posedge clock);
      csr_index <= gil_pkg::REG_NODES_J; csr_wdata <= nj;
      @(posedge clock);
      csr_index <= gil_pkg::REG_NODES_K; csr_wdata <= nk;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic random_word;
      logic [1:0] cmd;
      longint unsigned span;
      cmd = 2'($urandom);
      span = longint'(u_chk.fit_span(u_chk.span_i)) * u_chk.fit_span(u_chk.span_j)
         * u_chk.fit_span(u_chk.span_k);
      if ($urandom_range(3) != 0)
         send_word(cmd, 10'($urandom_range(u_chk.fit_span(u_chk.span_i) - 1)),
            10'($urandom_range(u_chk.fit_span(u_chk.span_j) - 1)),
            10'($urandom_range(u_chk.fit_span(u_chk.span_k) - 1)),
            30'($urandom_range(span > 32'h3FFFFFFF ? 32'h3FFFFFFF : 32'(span))));
      else
         send_word(cmd, 10'($urandom), 10'($urandom), 10'($urandom), 30'($urandom));
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      send_gap = 7; take_gap = 65;
      for (int c = 0; c < 4; c++) begin
         send_word(2'(c), 10'd0, 10'd0, 10'd0, 30'd0);
         send_word(2'(c), 10'd1, 10'd1, 10'd1, 30'd7);
         send_word(2'(c), 10'h3FF, 10'h3FF, 10'h3FF, 30'h3FFFFFFF);
      end
      drain();
      set_extents(11'd1024, 11'd1024, 11'd1024);
      for (int c = 0; c < 4; c++) begin
         send_word(2'(c), 10'h3FF, 10'h3FF, 10'h3FF, 30'h3FFFFFFF);
         send_word(2'(c), 10'h155, 10'h2AA, 10'h155, 30'h2AAAAAAA);
      end
      drain();
      set_extents(11'd0, 11'h7FF, 11'd1);
      for (int c = 0; c < 4; c++) send_word(2'(c), 10'd1, 10'h3FF, 10'd2, 30'h15555555);
      drain();
      for (int phase = 0; phase < 3; phase++) begin
         send_gap = (phase == 0) ? 7 : (phase == 1) ? 65 : 0;
         take_gap = (phase == 0) ? 65 : (phase == 1) ? 7 : 0;
         for (int s = 0; s < 3; s++) begin
            if (s == 2) set_extents(11'($urandom_range(2, 1024)),
                  11'($urandom_range(2, 1024)), 11'($urandom_range(2, 1024)));
            else if (s == 1) set_extents(11'($urandom_range(2, 12)),
                  11'($urandom_range(2, 12)), 11'($urandom_range(2, 12)));
            else set_extents(11'($urandom), 11'($urandom), 11'($urandom));
            if (phase == 2 && s == 0) begin
               fork
                  begin
                     hold_off = 1;
                     repeat (150) @(posedge clock);
                     hold_off = 0;
                  end
                  repeat (100) random_word();
               join
            end else begin
               repeat (100) random_word();
            end
            drain();
         end
      end
      if (fail_count == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end
endmodule
